// File: hw/rtl/krds_pkg.sv
package krds_pkg;

    localparam int KMER_LEN    = 8;
    localparam int POS_BITS    = 20;
    localparam int VAL_BITS    = POS_BITS + 1;
    localparam int CFG_BITS    = POS_BITS;
    localparam int BASE_BITS   = 2;
    localparam int KEY_BITS    = BASE_BITS * KMER_LEN;
    localparam int CNT_BITS    = $clog2(KMER_LEN + 1);
    localparam int TAIL_BITS   = $clog2(KMER_LEN);
    localparam int CLR_BITS    = (POS_BITS > KEY_BITS) ? POS_BITS : KEY_BITS;
    localparam int STORE_SIZE  = 1 << POS_BITS;
    localparam int TABLE_SIZE  = 1 << KEY_BITS;
    localparam int IN_TDATA_W  = ((BASE_BITS + POS_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((POS_BITS + VAL_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIST = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIST = 1'b1;

    localparam logic [CFG_BITS-1:0] MIN_DIST_RESET = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0] MAX_DIST_RESET = CFG_BITS'(15000);

endpackage

// File: hw/rtl/kmer_repeat_distance_scorer_unit.sv
// A base's first score record passes the K-mer read and the lookup and pair states before
// it reaches the output register. A full K-mer passes the lookup and pair states, plus the
// pair record state when the paired position is rewritten; a segment-final one then writes
// seven tail copies. After reset a clearing pass zeroes the score memory and K-mer valid
// bits, one entry per cycle; no base is accepted during it, configuration writes are taken.
module kmer_repeat_distance_scorer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [krds_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [krds_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0: base, position, zero fill.
    input  logic [krds_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // Field: segment_first.
    input  logic                                  i_s_tuser,
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // Fields from bit 0: write_position, write_value, zero fill.
    output logic [krds_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int POS_BITS  = krds_pkg::POS_BITS;
    localparam int VAL_BITS  = krds_pkg::VAL_BITS;
    localparam int KEY_BITS  = krds_pkg::KEY_BITS;
    localparam int CNT_BITS  = krds_pkg::CNT_BITS;
    localparam int TAIL_BITS = krds_pkg::TAIL_BITS;
    localparam int CLR_BITS  = krds_pkg::CLR_BITS;
    localparam int BASE_BITS = krds_pkg::BASE_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_PAIR = 3'd2;
    localparam logic [2:0] ST_PREC = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;

    localparam int CFG_BITS_L = krds_pkg::CFG_BITS;
    logic [CFG_BITS_L-1:0] r_min_dist;
    logic [CFG_BITS_L-1:0] r_max_dist;

    logic                  r_clearing;
    logic [CLR_BITS-1:0]   r_clr_addr;

    logic [KEY_BITS-1:0]   r_recent;
    logic [CNT_BITS-1:0]   r_count;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [2:0]            eng_next;
    logic [TAIL_BITS-1:0]  r_tail_j;
    logic [TAIL_BITS-1:0]  n_tail_j;

    logic [POS_BITS-1:0]   r_i;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_kok;
    logic                  r_final;
    logic                  r_match;
    logic [POS_BITS-1:0]   r_p;
    logic [POS_BITS-1:0]   r_d;
    logic signed [VAL_BITS-1:0] r_diff;
    logic signed [VAL_BITS-1:0] r_v;

    logic [VAL_BITS-1:0]   r_score_mem [krds_pkg::STORE_SIZE];
    logic [VAL_BITS-1:0]   r_score_rd_a;
    logic [VAL_BITS-1:0]   r_score_rd_b;
    logic [POS_BITS:0]     r_kmer_mem [krds_pkg::TABLE_SIZE];
    logic [POS_BITS:0]     r_kmer_rd;

    logic                  r_m_valid;
    logic [POS_BITS-1:0]   r_m_pos;
    logic signed [VAL_BITS-1:0] r_m_val;
    logic                  r_m_last;

    logic                  s_acc;
    logic                  in_first;
    logic                  in_final;
    logic [BASE_BITS-1:0]  in_base;
    logic [POS_BITS-1:0]   in_pos;
    logic [KEY_BITS-1:0]   rb0;
    logic [KEY_BITS-1:0]   rb1;
    logic [CNT_BITS-1:0]   cnt0;
    logic [CNT_BITS-1:0]   cnt1;
    logic                  acc_kok;

    logic                  k_seen;
    logic [POS_BITS-1:0]   k_pos;
    logic signed [VAL_BITS-1:0] look_diff;
    logic signed [VAL_BITS-1:0] look_neg;
    logic [POS_BITS-1:0]   look_d;
    logic                  look_match;

    logic signed [VAL_BITS-1:0] neg_diff;
    logic signed [VAL_BITS-1:0] old_val;
    logic signed [VAL_BITS-1:0] old_neg;
    logic [VAL_BITS-1:0]   old_abs;
    logic                  pair_cond;
    logic signed [VAL_BITS-1:0] pair_v;

    logic                  out_free;
    logic                  eng_emit;
    logic                  eng_adv;
    logic                  eng_done;
    logic [POS_BITS-1:0]   eng_pos;
    logic signed [VAL_BITS-1:0] eng_val;
    logic                  eng_last;
    logic                  look_adv;
    logic                  pair_adv;

    logic                  s_we;
    logic [POS_BITS-1:0]   s_waddr;
    logic [VAL_BITS-1:0]   s_wdata;
    logic                  k_we;

    logic                  mem_we;
    logic [POS_BITS-1:0]   mem_waddr;
    logic [VAL_BITS-1:0]   mem_wdata;
    logic                  kmem_we;
    logic [KEY_BITS-1:0]   kmem_waddr;
    logic [POS_BITS:0]     kmem_wdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= krds_pkg::MIN_DIST_RESET;
            r_max_dist <= krds_pkg::MAX_DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                krds_pkg::REG_MIN_DIST: r_min_dist <= i_cfg_data;
                krds_pkg::REG_MAX_DIST: r_max_dist <= i_cfg_data;
            endcase
        end
    end

    // Input decode and base history.
    assign in_base  = i_s_tdata[BASE_BITS-1:0];
    assign in_pos   = i_s_tdata[BASE_BITS+POS_BITS-1:BASE_BITS];
    assign in_first = i_s_tuser;
    assign in_final = i_s_tlast;
    assign s_acc    = i_s_tvalid && o_s_tready;

    always_comb begin
        rb0     = in_first ? '0 : r_recent;
        cnt0    = in_first ? '0 : r_count;
        rb1     = {rb0[KEY_BITS-BASE_BITS-1:0], in_base};
        cnt1    = (cnt0 < CNT_BITS'(krds_pkg::KMER_LEN)) ? cnt0 + CNT_BITS'(1) : cnt0;
        acc_kok = (cnt1 == CNT_BITS'(krds_pkg::KMER_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_count  <= '0;
        end else if (s_acc) begin
            r_recent <= in_final ? '0 : rb1;
            r_count  <= in_final ? '0 : cnt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_i     <= in_pos - POS_BITS'(krds_pkg::KMER_LEN - 1);
            r_key   <= rb1;
            r_kok   <= acc_kok;
            r_final <= in_final;
        end
    end

    // Lookup of the previous start of this K-mer.
    always_comb begin
        k_seen     = r_kmer_rd[POS_BITS];
        k_pos      = r_kmer_rd[POS_BITS-1:0];
        look_diff  = $signed({1'b0, r_i}) - $signed({1'b0, k_pos});
        look_neg   = -look_diff;
        look_d     = look_diff[VAL_BITS-1] ? look_neg[POS_BITS-1:0] : look_diff[POS_BITS-1:0];
        look_match = r_kok && k_seen && (look_d >= r_min_dist) && (look_d <= r_max_dist);
    end

    // Decision on the paired position and the tail value.
    always_comb begin
        neg_diff  = -r_diff;
        old_val   = (r_p == r_i) ? neg_diff : $signed(r_score_rd_b);
        old_neg   = -old_val;
        old_abs   = old_val[VAL_BITS-1] ? old_neg : old_val;
        pair_cond = r_match && ((old_val == '0) || ({1'b0, r_d} < old_abs));
        pair_v    = r_match ? neg_diff : $signed(r_score_rd_a);
    end

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        eng_next = r_state;
        n_tail_j = r_tail_j;
        eng_emit = 1'b0;
        eng_pos  = r_i;
        eng_val  = neg_diff;
        eng_last = 1'b0;
        eng_done = 1'b0;
        s_we     = 1'b0;
        s_waddr  = r_i;
        s_wdata  = neg_diff;
        k_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                eng_done = 1'b1;
            end
            ST_LOOK: begin
                k_we    = r_kok;
                s_we    = look_match;
                s_wdata = look_neg;
                if (r_kok) begin
                    eng_next = ST_PAIR;
                end else begin
                    eng_done = 1'b1;
                    eng_next = ST_IDLE;
                end
            end
            ST_PAIR: begin
                eng_emit = r_match;
                eng_last = !pair_cond && !r_final;
                s_we     = pair_cond;
                s_waddr  = r_p;
                s_wdata  = r_diff;
                n_tail_j = TAIL_BITS'(1);
                if (pair_cond) begin
                    eng_next = ST_PREC;
                end else if (r_final) begin
                    eng_next = ST_TAIL;
                end else begin
                    eng_done = 1'b1;
                    eng_next = ST_IDLE;
                end
            end
            ST_PREC: begin
                eng_emit = 1'b1;
                eng_pos  = r_p;
                eng_val  = r_diff;
                eng_last = !r_final;
                if (r_final) begin
                    eng_next = ST_TAIL;
                end else begin
                    eng_done = 1'b1;
                    eng_next = ST_IDLE;
                end
            end
            ST_TAIL: begin
                eng_emit = 1'b1;
                eng_pos  = r_i + POS_BITS'(r_tail_j);
                eng_val  = r_v;
                eng_last = (r_tail_j == TAIL_BITS'(krds_pkg::KMER_LEN - 1));
                s_we     = 1'b1;
                s_waddr  = r_i + POS_BITS'(r_tail_j);
                s_wdata  = r_v;
                n_tail_j = r_tail_j + TAIL_BITS'(1);
                if (eng_last) begin
                    eng_done = 1'b1;
                    eng_next = ST_IDLE;
                end
            end
            default: begin
                eng_next = ST_IDLE;
            end
        endcase
        eng_adv = !eng_emit || out_free;
        if (!eng_adv) begin
            eng_next = r_state;
            n_tail_j = r_tail_j;
            eng_done = 1'b0;
            s_we     = 1'b0;
        end
    end

    assign o_s_tready = !r_clearing && eng_done;
    assign n_state    = s_acc ? ST_LOOK : eng_next;
    assign look_adv   = (r_state == ST_LOOK);
    assign pair_adv   = (r_state == ST_PAIR) && eng_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tail_j <= '0;
        end else begin
            r_state  <= n_state;
            r_tail_j <= n_tail_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (look_adv) begin
            r_p     <= k_pos;
            r_diff  <= look_diff;
            r_d     <= look_d;
            r_match <= look_match;
        end
        if (pair_adv) begin
            r_v <= pair_v;
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + CLR_BITS'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign mem_we     = r_clearing || s_we;
    assign mem_waddr  = r_clearing ? r_clr_addr[POS_BITS-1:0] : s_waddr;
    assign mem_wdata  = r_clearing ? '0 : s_wdata;
    assign kmem_we    = r_clearing || k_we;
    assign kmem_waddr = r_clearing ? r_clr_addr[KEY_BITS-1:0] : r_key;
    assign kmem_wdata = r_clearing ? '0 : {1'b1, r_i};

    // Score memory: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_score_mem[mem_waddr] <= mem_wdata;
        end
        if (look_adv) begin
            r_score_rd_a <= r_score_mem[r_i];
            r_score_rd_b <= r_score_mem[k_pos];
        end
    end

    // K-mer memory: valid bit over the last start position.
    always_ff @(posedge i_clk) begin
        if (kmem_we) begin
            r_kmer_mem[kmem_waddr] <= kmem_wdata;
        end
        if (s_acc) begin
            r_kmer_rd <= r_kmer_mem[rb1];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= eng_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && eng_emit) begin
            r_m_pos  <= eng_pos;
            r_m_val  <= eng_val;
            r_m_last <= eng_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_m_last;
    assign o_m_tdata  = {{(krds_pkg::OUT_TDATA_W - POS_BITS - VAL_BITS){1'b0}},
                         r_m_val, r_m_pos};

    a_no_output_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_m_tvalid && (r_state == ST_IDLE)
    ) else $error("result or work during clearing pass");

    a_accept_starts_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_LOOK)
    ) else $error("accepted base did not start a lookup");

    a_pair_needs_match: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREC) |-> r_match
    ) else $error("pair record without a match");

    a_tail_only_final: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAIL) |-> r_final && r_kok && (r_tail_j != '0)
    ) else $error("tail copy outside a segment-final K-mer");

endmodule

// File: verif/tb_kmer_repeat_distance_scorer_unit.sv
module tb_kmer_repeat_distance_scorer_unit;
    import krds_pkg::*;

    localparam int CYCLE_LIMIT = STORE_SIZE + 400_000;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES  = 8;
    localparam int MAX_SHOWN   = 10;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 24;

    localparam int MIN_SETTING [NUM_PHASES] = '{100, 0, 1, 1000, 0, 2, 1048575, 0};
    localparam int MAX_SETTING [NUM_PHASES] = '{15000, 40, 2000, 999, 1048575, 12, 1048575, 0};

    typedef struct packed {
        logic [BASE_BITS-1:0] base;
        logic [POS_BITS-1:0]  pos;
        logic                 seg_first;
        logic                 seg_last;
    } base_item_t;

    typedef struct packed {
        logic [POS_BITS-1:0]        pos;
        logic signed [VAL_BITS-1:0] value;
        logic                       last;
    } score_write_t;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_BITS-1:0]      i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata = '0;
    logic                     i_s_tuser = 1'b0;
    logic                     i_s_tlast = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     o_m_tlast;

    kmer_repeat_distance_scorer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Scoring state mirrored from the block.
    logic [KEY_BITS-1:0]       recent_kmer = '0;
    int                        kmer_fill = 0;
    bit [POS_BITS-1:0]         kmer_start_of [TABLE_SIZE];
    bit                        kmer_valid [TABLE_SIZE];
    bit signed [VAL_BITS-1:0]  score_of [STORE_SIZE];
    logic [CFG_BITS-1:0]       min_dist = MIN_DIST_RESET;
    logic [CFG_BITS-1:0]       max_dist = MAX_DIST_RESET;

    score_write_t              score_writes_due [$];
    score_write_t              run_writes [$];
    base_item_t                pending_bases [$];
    base_item_t                offered_base;

    logic [BASE_BITS-1:0]      motif_bases [$];
    logic [POS_BITS-1:0]       motif_start = '0;

    int queued_count = 0;
    int accepted_count = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic post_score(input logic [POS_BITS-1:0] pos, input int value);
        score_write_t w;
        score_of[pos] = VAL_BITS'(value);
        w.pos = pos;
        w.value = VAL_BITS'(value);
        w.last = 1'b0;
        run_writes.insert(run_writes.size(), w);
    endtask

    task automatic predict_scores(input base_item_t it);
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] prev;
        int diff;
        int gap;
        int old;
        int old_mag;
        int tail;
        score_write_t w;
        run_writes.delete();
        if (it.seg_first) begin
            recent_kmer = '0;
            kmer_fill = 0;
        end
        recent_kmer = {recent_kmer[KEY_BITS-BASE_BITS-1:0], it.base};
        if (kmer_fill < KMER_LEN) kmer_fill++;
        if (kmer_fill == KMER_LEN) begin
            start = it.pos - POS_BITS'(KMER_LEN - 1);
            if (kmer_valid[recent_kmer]) begin
                prev = kmer_start_of[recent_kmer];
                diff = int'(start) - int'(prev);
                gap = (diff < 0) ? -diff : diff;
                if (gap >= int'(min_dist) && gap <= int'(max_dist)) begin
                    post_score(start, -diff);
                    old = score_of[prev];
                    old_mag = (old < 0) ? -old : old;
                    if (old == 0 || gap < old_mag) post_score(prev, diff);
                end
            end
            kmer_start_of[recent_kmer] = start;
            kmer_valid[recent_kmer] = 1'b1;
            if (it.seg_last) begin
                tail = score_of[start];
                for (int j = 1; j < KMER_LEN; j++) post_score(start + POS_BITS'(j), tail);
            end
        end
        if (it.seg_last) begin
            recent_kmer = '0;
            kmer_fill = 0;
        end
        foreach (run_writes[k]) begin
            w = run_writes[k];
            w.last = (k == run_writes.size() - 1);
            score_writes_due.insert(score_writes_due.size(), w);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MIN_DIST) min_dist = value;
        else max_dist = value;
    endtask

    task automatic queue_base(input logic [BASE_BITS-1:0] base, input logic [POS_BITS-1:0] pos,
                              input logic seg_first, input logic seg_last);
        base_item_t it;
        it.base = base;
        it.pos = pos;
        it.seg_first = seg_first;
        it.seg_last = seg_last;
        pending_bases.insert(pending_bases.size(), it);
        queued_count++;
    endtask

    task automatic wait_until_drained();
        while (accepted_count != queued_count || score_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Mostly well-formed segments rich in repeated K-mers, some placed at distances
    // that fall inside the current window; the rest is short or broken traffic.
    task automatic queue_phase_items();
        int target;
        int kind;
        int len;
        int period;
        int lo;
        int hi;
        int shift;
        int s;
        logic [POS_BITS-1:0] pos;
        logic [BASE_BITS-1:0] seg [$];
        target = queued_count + PHASE_ITEMS;
        while (queued_count < target) begin
            kind = $urandom_range(99);
            seg.delete();
            if (kind < 75) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(8, 20);
                if (motif_bases.size() != 0 && $urandom_range(1) == 1) begin
                    for (int k = 0; k < len; k++)
                        seg.insert(seg.size(), motif_bases[k % motif_bases.size()]);
                end else begin
                    period = $urandom_range(1, 12);
                    for (int k = 0; k < len; k++)
                        seg.insert(seg.size(),
                                   (k < period) ? BASE_BITS'($urandom) : seg[k - period]);
                end
                foreach (seg[k])
                    if ($urandom_range(15) == 0) seg[k] = BASE_BITS'($urandom);
                case ($urandom_range(5))
                    0: pos = POS_BITS'($urandom);
                    1, 2: begin
                        lo = int'(min_dist);
                        hi = int'(max_dist);
                        if (lo > hi) begin
                            lo = 0;
                            hi = 2000;
                        end else if (hi - lo > 3000) begin
                            hi = ($urandom_range(1) == 1) ? lo + 3000 : hi;
                            if (hi - lo > 3000) lo = hi - 3000;
                        end
                        shift = $urandom_range(hi, lo);
                        s = int'(motif_start);
                        if (s >= shift && $urandom_range(1) == 1) s = s - shift;
                        else if (s + shift < STORE_SIZE) s = s + shift;
                        else if (s >= shift) s = s - shift;
                        else s = $urandom_range(STORE_SIZE - 1);
                        pos = POS_BITS'(s);
                    end
                    3: pos = motif_start + POS_BITS'($urandom_range(1, 16));
                    4: pos = motif_start;
                    default: pos = ($urandom_range(1) == 1) ? '0 : POS_BITS'(STORE_SIZE - len);
                endcase
                foreach (seg[k])
                    queue_base(seg[k], pos + POS_BITS'(k),
                               (k == 0) && ($urandom_range(7) != 0),
                               (k == len - 1) && ($urandom_range(9) != 0));
                motif_bases = seg;
                motif_start = pos;
            end else begin
                len = $urandom_range(1, 7);
                pos = POS_BITS'($urandom);
                for (int k = 0; k < len; k++)
                    queue_base(BASE_BITS'($urandom),
                               (kind < 90) ? pos + POS_BITS'(k) : POS_BITS'($urandom),
                               (k == 0) ? 1'b1 : ($urandom_range(15) == 0),
                               (k == len - 1) ? ($urandom_range(1) == 1) : ($urandom_range(15) == 0));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_scores(offered_base);
                accepted_count++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_base = pending_bases.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= IN_TDATA_W'({offered_base.pos, offered_base.base});
                    i_s_tuser <= offered_base.seg_first;
                    i_s_tlast <= offered_base.seg_last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            i_m_tready <= 1'b0;
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        score_write_t got;
        score_write_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.pos = o_m_tdata[POS_BITS-1:0];
            got.value = o_m_tdata[POS_BITS +: VAL_BITS];
            got.last = o_m_tlast;
            if (score_writes_due.size() == 0) begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected score transaction: pos %0d value %0d last %0b",
                             got.pos, $signed(got.value), got.last);
                mismatches++;
            end else begin
                want = score_writes_due.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_SHOWN)
                        $display("score mismatch: expected pos %0d value %0d last %0b, got pos %0d value %0d last %0b",
                                 want.pos, $signed(want.value), want.last,
                                 got.pos, $signed(got.value), got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first segment wraps past the top of the position range, the
        // short one follows a final base without a start flag, and the last
        // one lands on the same K-mer start again for a zero distance.
        write_reg(REG_MIN_DIST, '0);
        write_reg(REG_MAX_DIST, '1);
        for (int k = 0; k < 9; k++)
            queue_base(2'd3, POS_BITS'(STORE_SIZE - 4 + k), k == 0, k == 8);
        for (int k = 0; k < 3; k++)
            queue_base(2'd0, POS_BITS'(k), 1'b0, k == 2);
        for (int k = 0; k < 8; k++)
            queue_base(2'd3, POS_BITS'(STORE_SIZE - 3 + k), k == 0, k == 7);
        wait_until_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(REG_MIN_DIST, CFG_BITS'(MIN_SETTING[ph]));
            write_reg(REG_MAX_DIST, CFG_BITS'(MAX_SETTING[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            queue_phase_items();
            if (ph == 4) hold_requests++;
            wait_until_drained();
        end

        if (mismatches == 0 && score_writes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/krds_pkg.sv
hw/rtl/kmer_repeat_distance_scorer_unit.sv
verif/tb_kmer_repeat_distance_scorer_unit.sv
